FILE: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and constants of the power scene controller.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int HINT_W        = 20;
  localparam int CNT_BITS_DEF  = 20;
  localparam logic [HINT_W-1:0] COOLDOWN_RST = 20'd3000;

  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 5;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W    = 24;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 8;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_EVENT = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // event codes
  localparam logic [3:0] EV_HEAVY_START = 4'd0;
  localparam logic [3:0] EV_HEAVY_END   = 4'd1;
  localparam logic [3:0] EV_DOWN        = 4'd2;
  localparam logic [3:0] EV_UP          = 4'd3;
  localparam logic [3:0] EV_SWIPE       = 4'd4;
  localparam logic [3:0] EV_GESTURE     = 4'd5;
  localparam logic [3:0] EV_JUNK        = 4'd6;
  localparam logic [3:0] EV_SWITCH      = 4'd7;
  localparam logic [3:0] EV_TIMEOUT     = 4'd8;

  // scenes
  localparam logic [2:0] SC_IDLE    = 3'd0;
  localparam logic [2:0] SC_TOUCH   = 3'd1;
  localparam logic [2:0] SC_TRIGGER = 3'd2;
  localparam logic [2:0] SC_GESTURE = 3'd3;
  localparam logic [2:0] SC_JUNK    = 3'd4;
  localparam logic [2:0] SC_SWITCH  = 3'd5;
  localparam logic [2:0] SC_BOOST   = 3'd6;

  // register indexes
  localparam logic [2:0] REG_TOUCH_HINT   = 3'd0;
  localparam logic [2:0] REG_TRIGGER_HINT = 3'd1;
  localparam logic [2:0] REG_GESTURE_HINT = 3'd2;
  localparam logic [2:0] REG_JUNK_HINT    = 3'd3;
  localparam logic [2:0] REG_SWITCH_HINT  = 3'd4;
  localparam logic [2:0] REG_COOLDOWN     = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] ev;
    logic       load_over;
  } item_t;

  typedef struct packed {
    logic [HINT_W-1:0] touch_hint;
    logic [HINT_W-1:0] trigger_hint;
    logic [HINT_W-1:0] gesture_hint;
    logic [HINT_W-1:0] junk_hint;
    logic [HINT_W-1:0] sw_hint;
    logic [HINT_W-1:0] cooldown;
  } cfg_t;

endpackage

FILE: rtl/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Accepts command words and classifies them into queue entries.
// ----------------------------------------------------------------------------
module pse_front import pse_pkg::*; (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TUSER_W-1:0] in_tuser,  // command
  input  logic [IN_TDATA_W-1:0] in_tdata,  // event_code, load_level, load_threshold
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  logic [9:0] load_level;
  logic [9:0] load_threshold;

  assign load_level     = in_tdata[13:4];
  assign load_threshold = in_tdata[23:14];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.cmd       = in_tuser;
    q_item.ev        = in_tdata[3:0];
    // load decision settled here, the back end only selects it
    q_item.load_over = (load_level > load_threshold);
  end

endmodule

FILE: rtl/pse_queue.sv
// ----------------------------------------------------------------------------
// pse_queue
// Short FIFO between the front end and the scene engine.
// ----------------------------------------------------------------------------
module pse_queue import pse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic [QUEUE_CNT_W-1:0] count_nxt;

  assign full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/pse_core.sv
// ----------------------------------------------------------------------------
// pse_core
// Scene engine: one queued command per cycle unless stalled; registers the result.
// ----------------------------------------------------------------------------
module pse_core import pse_pkg::*; #(
  parameter int COUNTER_BITS = CNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_empty,
  input  item_t                  q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CMP_W = (COUNTER_BITS > HINT_W) ? COUNTER_BITS : HINT_W;

  logic [2:0]              scene_r, scene_nxt;
  logic [COUNTER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [COUNTER_BITS-1:0] since_r, since_nxt;
  logic                    heavy_r, heavy_nxt;
  logic                    exit_r, exit_nxt;
  logic                    out_valid_r;
  logic [2:0]              out_scene_r;
  logic                    out_changed_r;
  logic                    out_boost_r;

  logic [COUNTER_BITS-1:0] elapsed_inc;
  logic [COUNTER_BITS-1:0] since_inc;
  logic [HINT_W-1:0]       hint;
  logic                    changed;
  logic                    boost;

  assign q_pop = !q_empty && (!out_valid_r || out_tready);

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign since_inc   = (since_r == '1) ? since_r : since_r + 1'b1;

  always_comb begin
    case (scene_r)
      SC_TOUCH:   hint = cfg.touch_hint;
      SC_TRIGGER: hint = cfg.trigger_hint;
      SC_GESTURE: hint = cfg.gesture_hint;
      SC_JUNK:    hint = cfg.junk_hint;
      SC_SWITCH:  hint = cfg.sw_hint;
      default:    hint = '0;
    endcase
  end

  always_comb begin
    scene_nxt   = scene_r;
    elapsed_nxt = elapsed_r;
    since_nxt   = since_r;
    heavy_nxt   = heavy_r;
    exit_nxt    = exit_r;
    boost       = 1'b0;
    case (q_head.cmd)
      CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        since_nxt   = since_inc;
        if (hint != '0 && CMP_W'(elapsed_inc) >= CMP_W'(hint)) begin
          scene_nxt = (scene_r == SC_TOUCH) ? SC_IDLE : SC_TOUCH;
        end
      end
      CMD_EVENT: begin
        if (q_head.ev == EV_HEAVY_START) begin
          heavy_nxt = 1'b1;
          scene_nxt = SC_BOOST;
        end else begin
          case (scene_r)
            SC_IDLE: begin
              if (q_head.ev == EV_DOWN) scene_nxt = SC_TOUCH;
              else if (q_head.ev == EV_SWITCH) scene_nxt = SC_SWITCH;
            end
            SC_TOUCH: begin
              if (q_head.ev == EV_UP) scene_nxt = SC_TRIGGER;
              else if (q_head.ev inside {EV_SWIPE, EV_GESTURE}) scene_nxt = SC_GESTURE;
              else if (q_head.ev == EV_JUNK) scene_nxt = SC_JUNK;
              else if (q_head.ev == EV_SWITCH) scene_nxt = SC_SWITCH;
              else if (q_head.ev == EV_TIMEOUT) scene_nxt = SC_IDLE;
            end
            SC_TRIGGER, SC_JUNK: begin
              if (q_head.ev inside {EV_TIMEOUT, EV_UP}) scene_nxt = SC_TOUCH;
              else if (q_head.ev == EV_SWITCH) scene_nxt = SC_SWITCH;
            end
            SC_GESTURE: begin
              if (q_head.ev == EV_TIMEOUT) scene_nxt = SC_TOUCH;
              else if (q_head.ev == EV_SWITCH) scene_nxt = SC_SWITCH;
            end
            SC_SWITCH: begin
              if (q_head.ev == EV_TIMEOUT) scene_nxt = SC_TOUCH;
            end
            SC_BOOST: begin
              // leaving boost on heavy_end starts the cooldown window
              if (q_head.ev == EV_HEAVY_END) begin
                heavy_nxt = 1'b0;
                exit_nxt  = 1'b1;
                since_nxt = '0;
                scene_nxt = SC_TOUCH;
              end else if (q_head.ev == EV_TIMEOUT) begin
                scene_nxt = SC_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_QUERY: begin
        if (heavy_r) begin
          boost = 1'b1;
        end else if (exit_r && CMP_W'(since_r) < CMP_W'(cfg.cooldown)) begin
          boost = 1'b0;
        end else begin
          boost = q_head.load_over;
        end
      end
      default: ;
    endcase
    changed = (scene_nxt != scene_r);
    if (changed) begin
      elapsed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scene_r     <= SC_IDLE;
      elapsed_r   <= '0;
      since_r     <= '0;
      heavy_r     <= 1'b0;
      exit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        scene_r     <= scene_nxt;
        elapsed_r   <= elapsed_nxt;
        since_r     <= since_nxt;
        heavy_r     <= heavy_nxt;
        exit_r      <= exit_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_scene_r   <= scene_nxt;
      out_changed_r <= changed;
      out_boost_r   <= boost;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_boost_r, out_changed_r, out_scene_r};

endmodule

FILE: rtl/power_scene_fsm.sv
// ----------------------------------------------------------------------------
// power_scene_fsm
// Scene controller for a power manager.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one command word per handshake; in_tuser carries the command
//   (tick, event, boost query), in_tdata the event code and the two load values.
//   Output stream: exactly one result word per command: scene after the
//   command, scene-changed flag and boost answer.
//   Configuration: APB-style port, six 20-bit registers at byte addresses
//   0x00..0x14 (five scene hint times, boost cooldown); write only while idle.
// Data flow:
//   An accepted command is first written into the queue; the scene engine
//   then pops it from the queue head and registers it into the result word,
//   which the receiver takes. One command per cycle is sustained while
//   out_tready stays high; the scene engine applies one queued command per
//   cycle, and the rate is set by that single registered state update.
// Reset and stall:
//   Synchronous reset returns the scene to idle, clears both timers and flags,
//   loads the register defaults and empties the four-word queue. While the
//   receiver holds out_tready low the result word stays, the queue keeps
//   filling, and in_tready drops once four words are waiting.
// ----------------------------------------------------------------------------
module power_scene_fsm import pse_pkg::*; #(
  parameter int COUNTER_BITS = CNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] command
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] event_code, [13:4] load_level,
                                             // [23:14] load_threshold
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [2:0] scene, [3] scene_changed,
                                             // [4] boost_needed, [7:5] zero
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_empty;
  item_t      q_item;
  item_t      q_head;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_hint   <= '0;
      cfg_r.trigger_hint <= '0;
      cfg_r.gesture_hint <= '0;
      cfg_r.junk_hint    <= '0;
      cfg_r.sw_hint      <= '0;
      cfg_r.cooldown     <= COOLDOWN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TOUCH_HINT:   cfg_r.touch_hint   <= cfg_pwdata[HINT_W-1:0];
        REG_TRIGGER_HINT: cfg_r.trigger_hint <= cfg_pwdata[HINT_W-1:0];
        REG_GESTURE_HINT: cfg_r.gesture_hint <= cfg_pwdata[HINT_W-1:0];
        REG_JUNK_HINT:    cfg_r.junk_hint    <= cfg_pwdata[HINT_W-1:0];
        REG_SWITCH_HINT:  cfg_r.sw_hint      <= cfg_pwdata[HINT_W-1:0];
        REG_COOLDOWN:     cfg_r.cooldown     <= cfg_pwdata[HINT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TOUCH_HINT:   cfg_prdata = CFG_DATA_W'(cfg_r.touch_hint);
      REG_TRIGGER_HINT: cfg_prdata = CFG_DATA_W'(cfg_r.trigger_hint);
      REG_GESTURE_HINT: cfg_prdata = CFG_DATA_W'(cfg_r.gesture_hint);
      REG_JUNK_HINT:    cfg_prdata = CFG_DATA_W'(cfg_r.junk_hint);
      REG_SWITCH_HINT:  cfg_prdata = CFG_DATA_W'(cfg_r.sw_hint);
      REG_COOLDOWN:     cfg_prdata = CFG_DATA_W'(cfg_r.cooldown);
      default:          cfg_prdata = '0;
    endcase
  end

  pse_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  pse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pse_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/pse_chk.sv
// ----------------------------------------------------------------------------
// pse_chk
// Port-level checks of the power scene controller, bound to the top level.
// ----------------------------------------------------------------------------
module pse_chk import pse_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_psel,
  input logic                   cfg_penable,
  input logic                   cfg_pwrite,
  input logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input logic [CFG_DATA_W-1:0]  cfg_prdata,
  input logic                   cfg_pready
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // a register read right after its write returns the written value
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
    && cfg_paddr[4:2] <= REG_COOLDOWN
    |=> !(cfg_psel && !cfg_pwrite && cfg_paddr[4:2] == $past(cfg_paddr[4:2]))
        || cfg_prdata == CFG_DATA_W'($past(cfg_pwdata[HINT_W-1:0])))
    else $error("register readback mismatch");

  // the pad bits of the result word stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'b000)
    else $error("result pad bits set");

endmodule

bind power_scene_fsm pse_chk u_pse_chk (.*);
